/* rtl/assert_macros.svh */
// Shared assertion macros for the limiter checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cllim_pkg.sv */
package cllim_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 16;
  localparam int GAIN_BITS     = COEF_BITS + 1;
  localparam int ENV_BITS      = SAMPLE_BITS - 1;
  localparam int DEF_NUM_BANDS = 4;
  localparam int DEF_MAX_DELAY = 256;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  // Shared divider geometry
  localparam int DIV_W       = 24;
  localparam int STEP_W      = 5;
  localparam int GAIN_STEPS  = 16;
  localparam int BLEND_STEPS = 22;

  localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(65536);

  // Register indexes
  localparam logic [2:0] REG_ACTIVE_BANDS = 3'd0;
  localparam logic [2:0] REG_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_ATTACK       = 3'd2;
  localparam logic [2:0] REG_RELEASE      = 3'd3;
  localparam logic [2:0] REG_DELAY        = 3'd4;

  localparam logic [2:0]  RST_ACTIVE_BANDS = 3'd4;
  localparam logic [63:0] RST_THRESHOLD    = 64'd9245186680414896205;
  localparam logic [63:0] RST_ATTACK       = 64'd18066747056855841465;
  localparam logic [63:0] RST_RELEASE      = 64'd18439425612644220901;
  localparam logic [63:0] RST_DELAY        = 64'd13511005043687472;

  typedef struct packed {
    logic [2:0]  active_bands;
    logic [63:0] threshold_word;
    logic [63:0] attack_word;
    logic [63:0] release_word;
    logic [63:0] delay_word;
  } cfg_t;

  function automatic logic [15:0] field_of(input logic [63:0] word, input logic [1:0] idx);
    logic [63:0] sh;
    sh = word >> {idx, 4'b0000};
    return sh[15:0];
  endfunction

endpackage

/* rtl/cascaded_lookahead_limiter_core.sv */
// Cascaded lookahead peak limiter, one signed Q1.23 sample per beat.
// Input channel: sample_in with in_valid/in_ready. Output channel: sample_out
// and dominant_gain with out_valid/out_ready. Registers sit on an APB-style
// port at byte addresses 8*i (64-bit data, pready tied high).
// One item at a time goes through a small sequencer that drives a single
// 25x18 multiplier and a shared shift-subtract divider. A limiting band
// spends 16 divider steps on its gain, and with more than one active band
// each band after the first spends 22 divider steps on the blend.
// in_ready is high only while the sequencer is idle; the next sample may be
// taken while the previous result still waits in the output register.
// After reset the delay memory is cleared one entry per cycle, all
// NUM_BANDS*MAX_DELAY entries, with in_ready low; register writes are taken.
// A stalled receiver holds the result and keeps the sequencer waiting at
// its last step; nothing is dropped.
module cascaded_lookahead_limiter_core #(
  parameter int NUM_BANDS = cllim_pkg::DEF_NUM_BANDS,
  parameter int MAX_DELAY = cllim_pkg::DEF_MAX_DELAY
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cllim_pkg::PADDR_W-1:0]          paddr,
  input  logic [cllim_pkg::PDATA_W-1:0]          pwdata,
  output logic [cllim_pkg::PDATA_W-1:0]          prdata,
  output logic                                   pready,
  input  logic signed [cllim_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  output logic signed [cllim_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic [cllim_pkg::GAIN_BITS-1:0]        dominant_gain,
  output logic                                   out_valid,
  input  logic                                   out_ready
);
  import cllim_pkg::*;

  localparam int BW    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int PW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DEPTH = NUM_BANDS * MAX_DELAY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ENV0 = 4'd2;
  localparam logic [3:0] S_ENV1 = 4'd3;
  localparam logic [3:0] S_ENV2 = 4'd4;
  localparam logic [3:0] S_DIVG = 4'd5;
  localparam logic [3:0] S_BL0  = 4'd6;
  localparam logic [3:0] S_BL1  = 4'd7;
  localparam logic [3:0] S_DIVB = 4'd8;
  localparam logic [3:0] S_DLY0 = 4'd9;
  localparam logic [3:0] S_DLY1 = 4'd10;
  localparam logic [3:0] S_DLY2 = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  cfg_t cfg;

  logic [3:0]                    state;
  logic [BW-1:0]                 band;
  logic [AW-1:0]                 clr_cnt;
  logic signed [SAMPLE_BITS-1:0] stage;
  logic [ENV_BITS-1:0]           mag;
  logic [ENV_BITS-1:0]           env [NUM_BANDS];
  logic [PW-1:0]                 pos [NUM_BANDS];
  logic [GAIN_BITS-1:0]          gain [NUM_BANDS];
  logic [GAIN_BITS-1:0]          min_gain;
  logic [18:0]                   gsum;
  logic signed [42:0]            prod;
  logic [40:0]                   acc;

  logic [2:0]           n3;
  logic [BW-1:0]        n_m1;
  logic                 last;
  logic [1:0]           fidx;
  logic [15:0]          thr;
  logic [15:0]          coef;
  logic [15:0]          dfield;
  logic [16:0]          len;
  logic [16:0]          pos_inc;
  logic [PW-1:0]        pos_next;
  logic [40:0]          env_sum;
  logic [ENV_BITS-1:0]  env_new;
  logic                 over;
  logic signed [24:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic [GAIN_BITS-1:0] gsel;
  logic signed [42:0]   psum;
  logic signed [26:0]   qv;
  logic signed [SAMPLE_BITS-1:0] sat_q;
  logic [21:0]          bnum;
  logic [GAIN_BITS-1:0] raw_gain;
  logic [GAIN_BITS-1:0] blend_gain;
  logic [ENV_BITS-1:0]  in_mag;

  logic                 div_start;
  logic [DIV_W-1:0]     div_rem;
  logic [DIV_W-1:0]     div_num;
  logic [DIV_W-1:0]     div_dvs;
  logic [STEP_W-1:0]    div_steps;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quot;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [AW-1:0]           dly_addr;
  logic [SAMPLE_BITS-1:0]  ram_wdata;
  logic [SAMPLE_BITS-1:0]  ram_rdata;

  cllim_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cllim_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .num      (div_num),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_quot)
  );

  cllim_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (dly_addr),
    .rdata (ram_rdata)
  );

  // Band count with out-of-range values folded into 1..NUM_BANDS
  always_comb begin
    if (cfg.active_bands == 3'd0) begin
      n3 = 3'd1;
    end else if (cfg.active_bands > 3'(NUM_BANDS)) begin
      n3 = 3'(NUM_BANDS);
    end else begin
      n3 = cfg.active_bands;
    end
  end

  assign n_m1 = BW'(n3 - 3'd1);
  assign last = (band == n_m1);
  assign fidx = 2'(band);
  assign thr  = field_of(cfg.threshold_word, fidx);
  assign coef = (mag > env[band]) ? field_of(cfg.attack_word, fidx)
                                  : field_of(cfg.release_word, fidx);

  assign in_mag = (sample_in == -24'sd8388608) ? 23'h7FFFFF
                : (sample_in[SAMPLE_BITS-1] ? 23'(-sample_in) : 23'(sample_in));

  // Delay length clamped to 1..MAX_DELAY
  assign dfield = field_of(cfg.delay_word, fidx);
  always_comb begin
    if (dfield == 16'd0) begin
      len = 17'd1;
    end else if ({1'b0, dfield} > 17'(MAX_DELAY)) begin
      len = 17'(MAX_DELAY);
    end else begin
      len = {1'b0, dfield};
    end
  end
  assign pos_inc  = 17'(pos[band]) + 17'd1;
  assign pos_next = (pos_inc >= len) ? '0 : PW'(pos_inc);
  assign dly_addr = AW'(band) * AW'(MAX_DELAY) + AW'(pos[band]);

  assign env_sum = acc + prod[40:0] + 41'd32768;
  assign env_new = env_sum[38:16];
  assign over    = env_new > {thr, 7'b0};

  assign gsel  = (band == '0) ? min_gain : gain[band];
  assign psum  = prod + 43'sd32768;
  assign qv    = psum[42:16];
  assign sat_q = (qv > 27'sd8388607)  ? 24'sh7FFFFF
               : (qv < -27'sd8388608) ? -24'sd8388608
               : qv[SAMPLE_BITS-1:0];

  assign bnum = 22'(prod[21:0]) + 22'({gsum, 1'b0}) + 22'(gsum)
              + 22'({n3, 2'b00}) + 22'(n3);

  // Only a limiting band reaches the gain division
  assign raw_gain   = GAIN_BITS'(div_quot[15:0]);
  assign blend_gain = (div_quot > DIV_W'(UNITY)) ? UNITY : div_quot[GAIN_BITS-1:0];

  // Shared multiplier operand select
  always_comb begin
    unique case (state)
      S_ENV0: begin
        mul_a = 25'(env[band]);
        mul_b = 18'(coef);
      end
      S_ENV1: begin
        mul_a = 25'(mag);
        mul_b = 18'(UNITY - GAIN_BITS'(coef));
      end
      S_BL0: begin
        mul_a = 25'(gain[band]);
        mul_b = 18'({n3, 3'b000} - {2'b00, n3});
      end
      S_DLY1: begin
        mul_a = {ram_rdata[SAMPLE_BITS-1], ram_rdata};
        mul_b = 18'(gsel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider launch: raw gain in ENV2, blend in BL1
  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_num   = '0;
    div_dvs   = '0;
    div_steps = '0;
    if (state == S_ENV2 && over) begin
      div_start = 1'b1;
      div_rem   = DIV_W'({thr, 7'b0});
      div_dvs   = DIV_W'(env_new);
      div_steps = STEP_W'(GAIN_STEPS);
    end else if (state == S_BL1) begin
      div_start = 1'b1;
      div_num   = {bnum, 2'b00};
      div_dvs   = DIV_W'({n3, 3'b000}) + DIV_W'({n3, 1'b0});
      div_steps = STEP_W'(BLEND_STEPS);
    end
  end

  assign ram_we    = (state == S_CLR) || (state == S_DLY1);
  assign ram_waddr = (state == S_CLR) ? clr_cnt : dly_addr;
  assign ram_wdata = (state == S_CLR) ? '0 : stage;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      band      <= '0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        env[i] <= '0;
        pos[i] <= '0;
      end
    end else begin
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            stage    <= sample_in;
            mag      <= in_mag;
            band     <= '0;
            min_gain <= UNITY;
            gsum     <= '0;
            state    <= S_ENV0;
          end
        end
        S_ENV0: begin
          state <= S_ENV1;
        end
        S_ENV1: begin
          acc   <= prod[40:0];
          state <= S_ENV2;
        end
        S_ENV2: begin
          env[band] <= env_new;
          if (over) begin
            state <= S_DIVG;
          end else begin
            gain[band] <= UNITY;
            gsum       <= gsum + 19'(UNITY);
            if (last) begin
              band  <= (n3 > 3'd1) ? BW'(1) : '0;
              state <= (n3 > 3'd1) ? S_BL0 : S_DLY0;
            end else begin
              band  <= band + BW'(1);
              state <= S_ENV0;
            end
          end
        end
        S_DIVG: begin
          if (div_done) begin
            gain[band] <= raw_gain;
            gsum       <= gsum + 19'(raw_gain);
            if (raw_gain < min_gain) begin
              min_gain <= raw_gain;
            end
            if (last) begin
              band  <= (n3 > 3'd1) ? BW'(1) : '0;
              state <= (n3 > 3'd1) ? S_BL0 : S_DLY0;
            end else begin
              band  <= band + BW'(1);
              state <= S_ENV0;
            end
          end
        end
        S_BL0: begin
          state <= S_BL1;
        end
        S_BL1: begin
          state <= S_DIVB;
        end
        S_DIVB: begin
          if (div_done) begin
            gain[band] <= blend_gain;
            if (last) begin
              band  <= '0;
              state <= S_DLY0;
            end else begin
              band  <= band + BW'(1);
              state <= S_BL0;
            end
          end
        end
        S_DLY0: begin
          state <= S_DLY1;
        end
        S_DLY1: begin
          // oldest sample was read last cycle; overwrite it with this stage's input
          pos[band] <= pos_next;
          state     <= S_DLY2;
        end
        S_DLY2: begin
          stage <= sat_q;
          if (last) begin
            state <= S_DONE;
          end else begin
            band  <= band + BW'(1);
            state <= S_DLY0;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the result beat until taken; load a new one when the register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      sample_out    <= stage;
      dominant_gain <= min_gain;
    end
  end

endmodule

/* rtl/cllim_ram.sv */
module cllim_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cllim_div.sv */
module cllim_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cllim_pkg::DIV_W-1:0]       rem_init,
  input  logic [cllim_pkg::DIV_W-1:0]       num,
  input  logic [cllim_pkg::DIV_W-1:0]       divisor,
  input  logic [cllim_pkg::STEP_W-1:0]      steps,
  output logic                              done,
  output logic [cllim_pkg::DIV_W-1:0]       quot
);
  import cllim_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  sh;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    trial;
  logic [DIV_W+1:0]  diff;
  logic              ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem, sh[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign ge    = ~diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      sh   <= num;
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      sh   <= {sh[DIV_W-2:0], 1'b0};
      quot <= {quot[DIV_W-2:0], ge};
    end
  end

endmodule

/* rtl/cllim_cfg.sv */
module cllim_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cllim_pkg::PADDR_W-1:0] paddr,
  input  logic [cllim_pkg::PDATA_W-1:0] pwdata,
  output logic [cllim_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output cllim_pkg::cfg_t               cfg
);
  import cllim_pkg::*;

  logic [2:0] idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_bands   <= RST_ACTIVE_BANDS;
      cfg.threshold_word <= RST_THRESHOLD;
      cfg.attack_word    <= RST_ATTACK;
      cfg.release_word   <= RST_RELEASE;
      cfg.delay_word     <= RST_DELAY;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_ACTIVE_BANDS: cfg.active_bands   <= pwdata[2:0];
        REG_THRESHOLD:    cfg.threshold_word <= pwdata;
        REG_ATTACK:       cfg.attack_word    <= pwdata;
        REG_RELEASE:      cfg.release_word   <= pwdata;
        REG_DELAY:        cfg.delay_word     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ACTIVE_BANDS: prdata = {61'd0, cfg.active_bands};
      REG_THRESHOLD:    prdata = cfg.threshold_word;
      REG_ATTACK:       prdata = cfg.attack_word;
      REG_RELEASE:      prdata = cfg.release_word;
      REG_DELAY:        prdata = cfg.delay_word;
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/cllim_checker.sv */
`include "assert_macros.svh"

module cllim_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   psel,
  input logic                                   penable,
  input logic                                   pwrite,
  input logic [cllim_pkg::PADDR_W-1:0]          paddr,
  input logic [cllim_pkg::PDATA_W-1:0]          pwdata,
  input logic [cllim_pkg::PDATA_W-1:0]          prdata,
  input logic                                   pready,
  input logic signed [cllim_pkg::SAMPLE_BITS-1:0] sample_in,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic signed [cllim_pkg::SAMPLE_BITS-1:0] sample_out,
  input logic [cllim_pkg::GAIN_BITS-1:0]        dominant_gain,
  input logic                                   out_valid,
  input logic                                   out_ready
);
  import cllim_pkg::*;

  // hold a stalled result
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(dominant_gain), "stalled result changed")
  // gain never exceeds unity
  `ASSERT_SAME(a_gain_range, out_valid, dominant_gain <= UNITY, "dominant gain above unity")
  // one item at a time
  `ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "input taken while busy")
  // leaving reset: no result, clearing pass under way
  `ASSERT_SAME(a_reset, $past(rst), !out_valid && !in_ready, "bad state after reset")

endmodule

bind cascaded_lookahead_limiter_core cllim_checker u_cllim_checker (.*);
